/* design/pps_pkg.sv */
// Shared types and constants for the periodic poll scheduler.
`default_nettype none
package pps_pkg;
  localparam int unsigned SLOTS = 16;
  localparam int unsigned SLOT_BITS = 4;
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned RATE_BITS = 24;
  localparam int unsigned CNT_BITS = 5;
  localparam logic [15:0] SLEEP_RESET_MS = 16'd50;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_PUSH   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_FINISH = 3'd3,
    OP_TICK   = 3'd4,
    OP_START  = 3'd5,
    OP_STOP   = 3'd6,
    OP_NONE   = 3'd7
  } op_e;

  typedef struct packed {
    logic                 accept;
    logic                 scan_rd;
    logic [SLOT_BITS-1:0] scan_idx;
    logic                 finish;
  } cmd_t;

  typedef struct packed {
    logic need_dispatch;
  } status_t;
endpackage
`default_nettype wire

/* design/pps_ctrl.sv */
// Controller: sequences accept, table scan, dispatch and result handshake.
`default_nettype none
module pps_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire pps_pkg::status_t status_i,
  output pps_pkg::cmd_t        cmd_o
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINAL} state_e;

  state_e                        state_q;
  logic [pps_pkg::SLOT_BITS-1:0] idx_q;
  logic                          out_valid_q;
  logic                          accept;

  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.scan_rd  = (state_q == S_SCAN);
    cmd_o.scan_idx = idx_q;
    cmd_o.finish   = (state_q == S_FINAL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            idx_q <= '0;
            if (status_i.need_dispatch) state_q <= S_SCAN;
            else out_valid_q <= 1'b1;
          end
        end
        S_SCAN: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == pps_pkg::SLOT_BITS'(pps_pkg::SLOTS - 1)) state_q <= S_DRAIN;
        end
        S_DRAIN: state_q <= S_FINAL;
        S_FINAL: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/pps_datapath.sv */
// Datapath: slot table, queue, clock, sleep timer, scan evaluation and results.
`default_nettype none
module pps_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pps_pkg::cmd_t                 cmd_i,
  output pps_pkg::status_t                   status_o,
  input  wire logic [2:0]                    operation_i,
  input  wire logic [3:0]                    slot_i,
  input  wire logic [23:0]                   rate_ms_i,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [0:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               issued_o,
  output logic [3:0]                         issued_slot_o,
  output logic                               slept_o,
  output logic [23:0]                        sleep_ms_o,
  output logic [4:0]                         queue_length_o,
  output logic                               busy_res_o
);
  localparam int unsigned N  = pps_pkg::SLOTS;
  localparam int unsigned SB = pps_pkg::SLOT_BITS;
  localparam int unsigned TB = pps_pkg::TIME_BITS;
  localparam int unsigned RB = pps_pkg::RATE_BITS;
  localparam int unsigned CB = pps_pkg::CNT_BITS;

  logic [RB-1:0] rate_mem [N];
  logic [TB-1:0] last_mem [N];
  logic [RB-1:0] rd_rate_q;
  logic [TB-1:0] rd_last_q;
  logic [SB-1:0] ev_slot_q;
  logic          ev_vld_q;

  logic [N-1:0]  valid_q, polled_q, mark_q;
  logic [SB-1:0] q_q [N];
  logic [CB-1:0] count_q;
  logic          active_q;
  logic [SB-1:0] active_slot_q;
  logic          stopped_q;
  logic [TB-1:0] time_q;
  logic [RB-1:0] sleep_left_q;
  logic          sleeping_q;
  logic [15:0]   def_sleep_q;
  logic [RB-1:0] best_q;
  logic          found_q;
  logic          issued_q, slept_q;
  logic [SB-1:0] issued_slot_q;
  logic [RB-1:0] sleep_ms_q;

  pps_pkg::op_e  op;
  logic [TB-1:0] elapsed;
  logic          ev_due, ev_later;
  logic [RB-1:0] ev_delay;
  logic [N-1:0]  hit, after;

  assign op = pps_pkg::op_e'(operation_i);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_sleep_q <= pps_pkg::SLEEP_RESET_MS;
    end else if (psel && penable && pwrite && (paddr == 1'b0)) begin
      def_sleep_q <= pwdata[15:0];
    end
  end
  assign prdata = (paddr == 1'b0) ? {16'd0, def_sleep_q} : 32'd0;

  always_comb begin
    status_o = '0;
    case (op)
      pps_pkg::OP_FINISH: status_o.need_dispatch = active_q;
      pps_pkg::OP_TICK:   status_o.need_dispatch = sleeping_q && !active_q &&
                                                   (sleep_left_q <= RB'(1));
      pps_pkg::OP_START:  status_o.need_dispatch = (count_q == '0) && !active_q;
      default:            status_o.need_dispatch = 1'b0;
    endcase
  end

  // Table memories with registered reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && op == pps_pkg::OP_ADD && !valid_q[slot_i])
      rate_mem[slot_i] <= rate_ms_i;
    if (cmd_i.accept && op == pps_pkg::OP_FINISH && active_q && valid_q[active_slot_q])
      last_mem[active_slot_q] <= time_q;
    rd_rate_q <= rate_mem[cmd_i.scan_idx];
    rd_last_q <= last_mem[cmd_i.scan_idx];
    ev_slot_q <= cmd_i.scan_idx;
  end

  assign elapsed  = time_q - rd_last_q;
  assign ev_later = polled_q[ev_slot_q] && (elapsed < {{(TB-RB){1'b0}}, rd_rate_q});
  assign ev_due   = valid_q[ev_slot_q] && !ev_later;
  assign ev_delay = rd_rate_q - elapsed[RB-1:0];

  // Locate a removed slot in the queue; entries at and above it move down.
  always_comb begin
    for (int i = 0; i < N; i++)
      hit[i] = (q_q[i] == slot_i) && (CB'(i) < count_q);
    after[0] = hit[0];
    for (int i = 1; i < N; i++) after[i] = after[i-1] | hit[i];
  end

  assign issued_o       = issued_q;
  assign issued_slot_o  = issued_slot_q;
  assign slept_o        = slept_q;
  assign sleep_ms_o     = sleep_ms_q;
  assign queue_length_o = count_q;
  assign busy_res_o     = active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_vld_q      <= 1'b0;
      valid_q       <= '0;
      polled_q      <= '0;
      mark_q        <= '0;
      count_q       <= '0;
      active_q      <= 1'b0;
      active_slot_q <= '0;
      stopped_q     <= 1'b0;
      time_q        <= '0;
      sleep_left_q  <= '0;
      sleeping_q    <= 1'b0;
      best_q        <= '0;
      found_q       <= 1'b0;
      issued_q      <= 1'b0;
      issued_slot_q <= '0;
      slept_q       <= 1'b0;
      sleep_ms_q    <= '0;
    end else begin
      ev_vld_q <= cmd_i.scan_rd;
      if (cmd_i.accept) begin
        issued_q      <= 1'b0;
        issued_slot_q <= '0;
        slept_q       <= 1'b0;
        sleep_ms_q    <= '0;
        found_q       <= 1'b0;
        best_q        <= '0;
        case (op)
          pps_pkg::OP_ADD: begin
            if (!valid_q[slot_i]) begin
              valid_q[slot_i]  <= 1'b1;
              polled_q[slot_i] <= 1'b0;
            end
          end
          pps_pkg::OP_PUSH: begin
            if (!mark_q[slot_i] && count_q < CB'(N)) begin
              for (int i = 1; i < N; i++) q_q[i] <= q_q[i-1];
              q_q[0]         <= slot_i;
              count_q        <= count_q + 1'b1;
              mark_q[slot_i] <= 1'b1;
            end
          end
          pps_pkg::OP_REMOVE: begin
            for (int i = 0; i < N - 1; i++)
              if (after[i]) q_q[i] <= q_q[i+1];
            if (mark_q[slot_i]) count_q <= count_q - 1'b1;
            mark_q[slot_i]   <= 1'b0;
            valid_q[slot_i]  <= 1'b0;
            polled_q[slot_i] <= 1'b0;
          end
          pps_pkg::OP_FINISH: begin
            if (active_q) begin
              if (valid_q[active_slot_q]) polled_q[active_slot_q] <= 1'b1;
              active_q <= 1'b0;
            end
          end
          pps_pkg::OP_TICK: begin
            time_q <= time_q + 1'b1;
            if (sleeping_q) begin
              if (sleep_left_q != '0) sleep_left_q <= sleep_left_q - 1'b1;
              if (sleep_left_q <= RB'(1)) sleeping_q <= 1'b0;
            end
          end
          pps_pkg::OP_START: begin
            if (count_q == '0 && !active_q) stopped_q <= 1'b0;
          end
          pps_pkg::OP_STOP: begin
            stopped_q <= 1'b1;
            count_q   <= '0;
            mark_q    <= '0;
          end
          default: ;
        endcase
      end
      // Evaluate one table entry: append if due, track the nearest due time.
      if (ev_vld_q) begin
        if (ev_due && !stopped_q && !mark_q[ev_slot_q] && count_q < CB'(N)) begin
          q_q[count_q[SB-1:0]] <= ev_slot_q;
          count_q              <= count_q + 1'b1;
          mark_q[ev_slot_q]    <= 1'b1;
        end
        if (valid_q[ev_slot_q] && ev_later && (!found_q || ev_delay < best_q)) begin
          best_q  <= ev_delay;
          found_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        if (count_q == '0) begin
          if (found_q) begin
            sleep_left_q <= best_q;
            sleep_ms_q   <= best_q;
          end else if (def_sleep_q == '0) begin
            sleep_left_q <= RB'(1);
            sleep_ms_q   <= RB'(1);
          end else begin
            sleep_left_q <= RB'(def_sleep_q);
            sleep_ms_q   <= RB'(def_sleep_q);
          end
          sleeping_q <= 1'b1;
          slept_q    <= 1'b1;
        end else begin
          for (int i = 0; i < N - 1; i++) q_q[i] <= q_q[i+1];
          count_q         <= count_q - 1'b1;
          mark_q[q_q[0]]  <= 1'b0;
          active_q        <= 1'b1;
          active_slot_q   <= q_q[0];
          issued_q        <= 1'b1;
          issued_slot_q   <= q_q[0];
        end
      end
    end
  end
endmodule
`default_nettype wire

/* design/periodic_poll_scheduler.sv */
// An item that does not dispatch gives its result in the cycle after it is taken;
// one that dispatches first scans the table (one table entry read per cycle over
// 16 entries), then issues a slot or sleeps. No new item is taken while one is in
// flight; the next item is taken the cycle after the result is taken. Reset clears
// table marks, queue, clock and sleep state at once; default sleep returns to 50 ms.
`default_nettype none
module periodic_poll_scheduler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [3:0]  slot_i,
  input  wire logic [23:0] rate_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             issued_o,
  output logic [3:0]       issued_slot_o,
  output logic             slept_o,
  output logic [23:0]      sleep_ms_o,
  output logic [4:0]       queue_length_o,
  output logic             busy_res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  pps_pkg::cmd_t    cmd;
  pps_pkg::status_t status;

  assign pready = 1'b1;

  pps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pps_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .operation_i    (operation_i),
    .slot_i         (slot_i),
    .rate_ms_i      (rate_ms_i),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .issued_o       (issued_o),
    .issued_slot_o  (issued_slot_o),
    .slept_o        (slept_o),
    .sleep_ms_o     (sleep_ms_o),
    .queue_length_o (queue_length_o),
    .busy_res_o     (busy_res_o)
  );
endmodule
`default_nettype wire
